FILE: src/tafgs_pkg.sv
// Shared types and constants for the free-group search block.
package tafgs_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_BADIDX   = 2'd2;

  localparam logic [1:0] REG_GPT  = 2'd0;
  localparam logic [1:0] REG_MGMT = 2'd1;
  localparam logic [1:0] REG_LAST = 2'd2;
  localparam logic [1:0] REG_FREE = 2'd3;

  localparam logic [6:0] GPT_RST  = 7'd2;
  localparam logic [7:0] MGMT_RST = 8'd0;
  localparam logic [7:0] LAST_RST = 8'd159;
  localparam logic [7:0] FREE_RST = 8'd255;
  localparam logic [7:0] ENTRY_RST = 8'hFF;

  localparam logic [2:0] RES_OK       = 3'd0;
  localparam logic [2:0] RES_BADIDX   = 3'd1;
  localparam logic [2:0] RES_READ     = 3'd2;
  localparam logic [2:0] RES_FOUND    = 3'd3;
  localparam logic [2:0] RES_NOTFOUND = 3'd4;

  typedef struct packed {
    logic       take;
    logic       wr;
    logic       init;
    logic       run;
    logic       set_res;
    logic [2:0] res_code;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_ok;
    logic       hit;
    logic       search_end;
  } sts_t;

endpackage

FILE: src/tafgs_dp.sv
// Datapath: configuration registers, allocation table, search counters, result registers.
module tafgs_dp import tafgs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [1:0] operation,
  input  logic [7:0] group_index,
  input  logic [7:0] entry_value,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic [1:0] status,
  output logic [7:0] result_value
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [6:0] groups_per_track;
  logic [7:0] management_start_group;
  logic [7:0] last_group;
  logic [7:0] free_code;

  logic [1:0] op_q;
  logic [7:0] idx_q;
  logic [7:0] val_q;

  logic [7:0]             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic [7:0]             rd_data;
  logic                   vld_q;
  logic [AW-1:0]          rd_addr;
  logic [7:0]             entry;

  logic [8:0]  i_cnt;
  logic [8:0]  steps;
  logic [6:0]  j_cnt;
  logic        upper;
  logic [9:0]  span;
  logic        pipe_vld;
  logic [7:0]  pipe_cand;

  logic [1:0]  res_status;
  logic [7:0]  res_value;

  logic [6:0]  g_eff;
  logic [8:0]  diff;
  logic [7:0]  d_val;
  logic        idx_ok;
  logic        issue_done;
  logic [11:0] cand;
  logic        cand_ok;
  logic        hit;

  assign g_eff = (groups_per_track == 7'd0) ? 7'd1 : groups_per_track;
  assign diff  = {1'b0, last_group} - {1'b0, management_start_group};
  assign d_val = (last_group >= management_start_group && diff[7:0] >= management_start_group)
                 ? diff[7:0] : management_start_group;

  assign idx_ok = (idx_q <= last_group) && (9'({1'b0, idx_q}) < 9'(TABLE_DEPTH));

  assign issue_done = (i_cnt == steps);
  assign cand = upper ? ({4'b0, management_start_group} + {2'b0, span} + {5'b0, j_cnt})
                      : ({4'b0, management_start_group} - {2'b0, span} + {5'b0, j_cnt});
  assign cand_ok = !cand[11] && (cand <= {4'b0, last_group}) && (cand < 12'(TABLE_DEPTH));

  assign rd_addr = cmd.run ? cand[AW-1:0] : idx_q[AW-1:0];
  assign entry   = vld_q ? rd_data : ENTRY_RST;
  assign hit     = pipe_vld && (entry == free_code);

  assign sts.op         = op_q;
  assign sts.idx_ok     = idx_ok;
  assign sts.hit        = hit;
  assign sts.search_end = issue_done && !pipe_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_track       <= GPT_RST;
      management_start_group <= MGMT_RST;
      last_group             <= LAST_RST;
      free_code              <= FREE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GPT:  groups_per_track       <= cfg_data[6:0];
        REG_MGMT: management_start_group <= cfg_data;
        REG_LAST: last_group             <= cfg_data;
        REG_FREE: free_code              <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q  <= operation;
      idx_q <= group_index;
      val_q <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && idx_ok) begin
      mem[idx_q[AW-1:0]] <= val_q;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.wr && idx_ok) begin
      vld[idx_q[AW-1:0]] <= 1'b1;
    end
    vld_q <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      steps <= {d_val, 1'b0};
      i_cnt <= '0;
      j_cnt <= '0;
      upper <= 1'b0;
      span  <= {3'b0, g_eff};
    end else if (cmd.run && !issue_done) begin
      i_cnt <= i_cnt + 9'd1;
      if (j_cnt == g_eff - 7'd1) begin
        j_cnt <= '0;
        if (upper) begin
          upper <= 1'b0;
          span  <= span + {3'b0, g_eff};
        end else begin
          upper <= 1'b1;
        end
      end else begin
        j_cnt <= j_cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
    end else begin
      pipe_vld <= cmd.run && !issue_done && cand_ok;
    end
    pipe_cand <= cand[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res_code)
        RES_OK: begin
          res_status <= ST_OK;
          res_value  <= '0;
        end
        RES_BADIDX: begin
          res_status <= ST_BADIDX;
          res_value  <= '0;
        end
        RES_READ: begin
          res_status <= ST_OK;
          res_value  <= entry;
        end
        RES_FOUND: begin
          res_status <= ST_OK;
          res_value  <= pipe_cand;
        end
        RES_NOTFOUND: begin
          res_status <= ST_NOTFOUND;
          res_value  <= '0;
        end
        default: begin
          res_status <= ST_OK;
          res_value  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      result_value <= res_value;
    end
  end

endmodule

FILE: src/tafgs_ctrl.sv
// Controller: sequences one operation at a time and owns the output beat valid.
module tafgs_ctrl import tafgs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = RES_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          OP_WRITE: begin
            cmd.wr       = 1'b1;
            cmd.set_res  = 1'b1;
            cmd.res_code = sts.idx_ok ? RES_OK : RES_BADIDX;
            state_next   = S_FINISH;
          end
          OP_READ: begin
            if (sts.idx_ok) begin
              state_next = S_RDWAIT;
            end else begin
              cmd.set_res  = 1'b1;
              cmd.res_code = RES_BADIDX;
              state_next   = S_FINISH;
            end
          end
          OP_FIND: begin
            cmd.init   = 1'b1;
            state_next = S_SEARCH;
          end
          default: begin
            cmd.set_res  = 1'b1;
            cmd.res_code = RES_OK;
            state_next   = S_FINISH;
          end
        endcase
      end
      S_RDWAIT: begin
        cmd.set_res  = 1'b1;
        cmd.res_code = RES_READ;
        state_next   = S_FINISH;
      end
      S_SEARCH: begin
        cmd.run = 1'b1;
        if (sts.hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_FOUND;
          state_next   = S_FINISH;
        end else if (sts.search_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = RES_NOTFOUND;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/track_alternating_free_group_search.sv
// Top level: allocation table with entry access and outward free-group search.
//
// Input channel (in_valid/in_stall) carries one operation per beat: write an
// entry, read an entry, or find a free group. Output channel (out_valid/
// out_stall) returns one beat per operation with status and result_value.
// The user must write configuration registers through cfg_write/cfg_index/
// cfg_data only while the block is idle; the block does not enforce it.
// The find loop issues one table read per cycle through the single read
// port; the compare runs in the next cycle and stops at the first free hit.
// One operation is in work at a time; a new beat is taken as soon as the
// previous result sits in the output register, even if it is stalled.
// A stalled output beat holds; the block waits to deliver the next result.
// Reset is synchronous: configuration returns to its defaults and every
// table entry reads as 255 immediately, with no clearing pass.
module track_alternating_free_group_search import tafgs_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] group_index,
  input  logic [7:0] entry_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [7:0] result_value
);

  cmd_t cmd;
  sts_t sts;

  tafgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tafgs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .group_index  (group_index),
    .entry_value  (entry_value),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .result_value (result_value)
  );

endmodule
